// ----- design/dnp_pkg.sv -----
// Types and constants shared by the decimal number parser files.
package dnp_pkg;

  // Fraction digits kept; later digits are dropped
  localparam int unsigned MAX_FRAC_DIGITS = 18;

  localparam int unsigned INT_W   = 64;
  localparam int unsigned FRAC_W  = 60;
  localparam int unsigned COUNT_W = 5;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_POINT  = 8'h2e;
  localparam logic [7:0] CH_SUFFIX = 8'h66;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_INVALID = 2'd0,
    STATUS_INTEGER = 2'd1,
    STATUS_DECIMAL = 2'd2
  } status_t;

  // Parser phase, one-hot
  typedef enum logic [4:0] {
    PH_START = 5'b00001,
    PH_INT   = 5'b00010,
    PH_FRAC  = 5'b00100,
    PH_DONE  = 5'b01000,
    PH_BAD   = 5'b10000
  } phase_t;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] char_code;
  } char_t;

  // Result transaction payload
  typedef struct packed {
    logic [1:0]              status;
    logic                    negative;
    logic signed [INT_W-1:0] int_value;
    logic [FRAC_W-1:0]       frac_numerator;
    logic [COUNT_W-1:0]      frac_digits;
  } result_t;

endpackage

// ----- design/dnp_stream_if.sv -----
// Valid/ready stream interface carrying one payload per transaction.
interface dnp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/decimal_number_parser_core.sv -----
// Decimal number parser: one character per transaction, one result per string.
//
//   channel   dir  payload                                                  transactions
//   in_chan   in   char_code                                                one per character
//   out_chan  out  status, negative, int_value, frac_numerator, frac_digits one per zero byte
//
// One character is accepted every cycle while no zero byte waits in the input register; the
// parser state takes a character's update at the edge where it leaves the input register.
// A result is loaded into the output register at the edge where its zero byte leaves
// the input register. Only a zero byte waits on a full output register; other
// characters flow past a stalled result.
// Synchronous reset returns the parser to the start of a string and empties
// both registers.
module decimal_number_parser_core
  import dnp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  dnp_stream_if.sink   in_chan,
  dnp_stream_if.source out_chan
);

  // Input register
  logic       s1_valid;
  logic [7:0] s1_char;

  // Parser state
  phase_t             phase;
  phase_t             phase_next;
  logic               minus_seen;
  logic               minus_seen_next;
  logic [INT_W-1:0]   int_accum;
  logic [INT_W-1:0]   int_accum_next;
  logic [FRAC_W-1:0]  frac_accum;
  logic [FRAC_W-1:0]  frac_accum_next;
  logic [COUNT_W-1:0] frac_count;
  logic [COUNT_W-1:0] frac_count_next;
  logic               frac_any;
  logic               frac_any_next;

  // Output register
  logic    out_valid;
  result_t out_data;
  result_t result_next;

  logic             s1_term;
  logic             s1_adv;
  logic             s1_digit;
  logic [INT_W-1:0] digit_ext;

  assign s1_term  = (s1_char == CH_NUL);
  assign s1_digit = s1_char inside {[CH_ZERO:CH_NINE]};
  assign digit_ext = {{(INT_W-4){1'b0}}, 4'(s1_char - CH_ZERO)};

  // Advance the input register unless a result is blocked behind the output
  assign s1_adv = s1_valid && (!s1_term || !out_valid || out_chan.ready);
  assign in_chan.ready = !s1_valid || s1_adv;

  // Next parser state for one non-terminating character
  always_comb begin
    phase_next      = phase;
    minus_seen_next = minus_seen;
    int_accum_next  = int_accum;
    frac_accum_next = frac_accum;
    frac_count_next = frac_count;
    frac_any_next   = frac_any;
    case (phase)
      PH_START, PH_INT: begin
        if ((phase == PH_START) && (s1_char == CH_MINUS)) begin
          minus_seen_next = 1'b1;
          phase_next      = PH_INT;
        end else if (s1_char == CH_POINT) begin
          phase_next = PH_FRAC;
        end else if (s1_digit) begin
          phase_next     = PH_INT;
          int_accum_next = (int_accum << 3) + (int_accum << 1) + digit_ext;
        end else begin
          phase_next = PH_BAD;
        end
      end
      PH_FRAC: begin
        if (s1_char == CH_SUFFIX) begin
          phase_next = frac_any ? PH_DONE : PH_BAD;
        end else if (s1_digit) begin
          frac_any_next = 1'b1;
          if (frac_count < COUNT_W'(MAX_FRAC_DIGITS)) begin
            frac_accum_next = (frac_accum << 3) + (frac_accum << 1)
                              + digit_ext[FRAC_W-1:0];
            frac_count_next = frac_count + 1'b1;
          end
        end else begin
          phase_next = PH_BAD;
        end
      end
      default: begin
      end
    endcase
  end

  // Result formed from the state at the terminator
  always_comb begin
    result_next = '0;
    if (phase == PH_BAD) begin
      result_next.status = STATUS_INVALID;
    end else begin
      result_next.negative  = minus_seen;
      result_next.int_value = minus_seen ? (INT_W'(0) - int_accum) : int_accum;
      if ((phase == PH_START) || (phase == PH_INT)) begin
        result_next.status = STATUS_INTEGER;
      end else begin
        result_next.status         = STATUS_DECIMAL;
        result_next.frac_numerator = frac_accum;
        result_next.frac_digits    = frac_count;
      end
    end
  end

  // Input register: hold while blocked, load on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid <= in_chan.valid;
    end
    if (in_chan.valid && in_chan.ready) begin
      s1_char <= in_chan.data.char_code;
    end
  end

  // Parser state: update per character, clear after the terminator
  always_ff @(posedge clk) begin
    if (rst || (s1_adv && s1_term)) begin
      phase      <= PH_START;
      minus_seen <= 1'b0;
      int_accum  <= '0;
      frac_accum <= '0;
      frac_count <= '0;
      frac_any   <= 1'b0;
    end else if (s1_adv) begin
      phase      <= phase_next;
      minus_seen <= minus_seen_next;
      int_accum  <= int_accum_next;
      frac_accum <= frac_accum_next;
      frac_count <= frac_count_next;
      frac_any   <= frac_any_next;
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_term) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && s1_term) begin
      out_data <= result_next;
    end
  end

  assign out_chan.valid = out_valid;
  assign out_chan.data  = out_data;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the decimal number parser core.
`timescale 1ns / 100ps

module tb
  import dnp_pkg::*;
();

  typedef logic [7:0] text_t[$];

  // Track the string being parsed and hold the numbers it must yield
  class number_scoreboard;
    result_t            pending_numbers[$];
    int unsigned        failures;
    phase_t             phase;
    logic               minus_seen;
    logic               frac_any;
    logic [INT_W-1:0]   int_accum;
    logic [FRAC_W-1:0]  frac_accum;
    logic [COUNT_W-1:0] frac_count;

    function new();
      failures = 0;
      clear_string();
    endfunction

    function void clear_string();
      phase      = PH_START;
      minus_seen = 1'b0;
      frac_any   = 1'b0;
      int_accum  = '0;
      frac_accum = '0;
      frac_count = '0;
    endfunction

    // Count a failure; report only the first ten in full
    function void note_failure(string msg);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] %s", $realtime, msg);
      end
    endfunction

    // Advance the parse by one accepted character
    function void note_char(logic [7:0] code);
      result_t    num;
      logic       is_digit;
      logic [3:0] digit;
      is_digit = code inside {[CH_ZERO:CH_NINE]};
      digit    = 4'(code - CH_ZERO);
      if (code == CH_NUL) begin
        num = '0;
        if (phase == PH_BAD) begin
          num.status = STATUS_INVALID;
        end else begin
          num.negative  = minus_seen;
          num.int_value = minus_seen ? -int_accum : int_accum;
          if (phase == PH_START || phase == PH_INT) begin
            num.status = STATUS_INTEGER;
          end else begin
            num.status         = STATUS_DECIMAL;
            num.frac_numerator = frac_accum;
            num.frac_digits    = frac_count;
          end
        end
        pending_numbers.insert(pending_numbers.size(), num);
        clear_string();
      end else if (phase == PH_START && code == CH_MINUS) begin
        minus_seen = 1'b1;
        phase      = PH_INT;
      end else begin
        // A first character other than minus is an integer character
        if (phase == PH_START) phase = PH_INT;
        case (phase)
          PH_INT: begin
            if (code == CH_POINT) phase = PH_FRAC;
            else if (is_digit) int_accum = int_accum * 64'd10 + 64'(digit);
            else phase = PH_BAD;
          end
          PH_FRAC: begin
            if (code == CH_SUFFIX) begin
              phase = frac_any ? PH_DONE : PH_BAD;
            end else if (is_digit) begin
              frac_any = 1'b1;
              // Drop digits past the kept width
              if (frac_count < MAX_FRAC_DIGITS) begin
                frac_accum = frac_accum * 60'd10 + 60'(digit);
                frac_count = frac_count + 5'd1;
              end
            end else begin
              phase = PH_BAD;
            end
          end
          default: ;
        endcase
      end
    endfunction

    // Compare one result transaction with the oldest pending number
    function void check_result(result_t got);
      result_t want;
      if (pending_numbers.size() == 0) begin
        note_failure($sformatf("unexpected result: status %0d int %0d",
                               got.status, got.int_value));
        return;
      end
      want = pending_numbers.pop_front();
      if (got.status !== want.status || got.negative !== want.negative ||
          got.int_value !== want.int_value ||
          got.frac_numerator !== want.frac_numerator ||
          got.frac_digits !== want.frac_digits) begin
        note_failure({
          $sformatf("mismatch: expected st %0d neg %0d int %0d frac %0d/%0d",
                    want.status, want.negative, want.int_value,
                    want.frac_numerator, want.frac_digits),
          $sformatf(", got st %0d neg %0d int %0d frac %0d/%0d",
                    got.status, got.negative, got.int_value,
                    got.frac_numerator, got.frac_digits)});
      end
    endfunction

    function int pending_count();
      return pending_numbers.size();
    endfunction

    function void check_drained();
      if (pending_numbers.size() != 0) begin
        note_failure($sformatf("%0d results never arrived", pending_numbers.size()));
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   results_taken;
  int   random_chars;
  bit   out_idle;

  number_scoreboard sb = new();

  dnp_stream_if #(.payload_t(char_t))   char_if ();
  dnp_stream_if #(.payload_t(result_t)) number_if ();

  decimal_number_parser_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (char_if),
    .out_chan (number_if)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Offer one character and hold it until the transaction completes
  task automatic send_char(input logic [7:0] code, input bit idle);
    int gap;
    gap = idle ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_if.valid <= 1'b1;
    char_if.data  <= code;
    do @(posedge clk); while (!char_if.ready);
    sb.note_char(code);
  endtask

  task automatic send_string(input text_t s);
    bit idle;
    idle = ($urandom_range(0, 3) != 0);
    foreach (s[i]) send_char(s[i], idle);
  endtask

  // Take one result after a drawn hold-off and check it
  task automatic take_result(input int gap);
    @(negedge clk);
    if (gap > 0) begin
      number_if.ready <= 1'b0;
      for (int cycle = 0; cycle < gap; cycle++) @(negedge clk);
    end
    number_if.ready <= 1'b1;
    do @(posedge clk); while (!number_if.valid);
    sb.check_result(number_if.data);
    results_taken++;
  endtask

  function automatic text_t from_text(string t);
    text_t s;
    for (int i = 0; i < t.len(); i++) s.insert(s.size(), t[i]);
    s.insert(s.size(), CH_NUL);
    return s;
  endfunction

  // Mostly short digit runs, sometimes long enough to wrap or drop digits
  function automatic int run_length();
    if ($urandom_range(0, 3) != 0) return $urandom_range(0, 4);
    return $urandom_range(15, 24);
  endfunction

  // Build a well-formed number with random content, then break some of them
  function automatic text_t make_number();
    text_t s;
    int    n;
    if ($urandom_range(0, 1) != 0) s.insert(s.size(), CH_MINUS);
    n = run_length();
    repeat (n) s.insert(s.size(), 8'(CH_ZERO + $urandom_range(0, 9)));
    if ($urandom_range(0, 4) < 3) begin
      s.insert(s.size(), CH_POINT);
      n = run_length();
      repeat (n) s.insert(s.size(), 8'(CH_ZERO + $urandom_range(0, 9)));
      if (n > 0 && $urandom_range(0, 2) == 0) begin
        s.insert(s.size(), CH_SUFFIX);
        repeat ($urandom_range(0, 3)) s.insert(s.size(), 8'($urandom_range(1, 255)));
      end
    end
    case ($urandom_range(0, 9))
      0: s.insert($urandom_range(0, s.size()), 8'($urandom_range(1, 255)));
      1: s.insert($urandom_range(0, s.size()), CH_MINUS);
      2: s.insert($urandom_range(0, s.size()), CH_POINT);
      3: s.insert(s.size(), CH_SUFFIX);
      4: begin
        s.delete();
        repeat ($urandom_range(1, 6)) s.insert(s.size(), 8'($urandom_range(1, 255)));
      end
      default: ;
    endcase
    s.insert(s.size(), CH_NUL);
    return s;
  endfunction

  // Receive results for the whole run, with one long hold-off
  initial begin
    number_if.ready = 1'b0;
    results_taken   = 0;
    out_idle        = 1'b1;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) out_idle = !out_idle;
      if (results_taken == 20) take_result(300);
      else take_result(out_idle ? $urandom_range(0, 16) : 0);
    end
  end

  // Stop a hung run
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    text_t s;
    int    strings;
    rst           = 1'b1;
    char_if.valid = 1'b0;
    char_if.data  = '0;
    random_chars  = 0;
    strings       = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty, lone minus, bare point, suffix without digits,
    // late minus, bytes after suffix, bytes after an invalid top byte
    send_string(from_text(""));
    send_string(from_text("-"));
    send_string(from_text("."));
    send_string(from_text("1.f"));
    send_string(from_text("1-"));
    send_string(from_text("-7.5fx"));
    s = from_text("9");
    s.push_front(8'hff);
    send_string(s);

    // Random strings
    while (random_chars < 600) begin
      if (strings == 40) begin
        // Hold the input until every number has come out
        @(negedge clk);
        char_if.valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge clk);
      end
      s = make_number();
      send_string(s);
      random_chars += s.size();
      strings++;
    end

    @(negedge clk);
    char_if.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.check_drained();
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
